FILE: hw/rtl/ctb_pkg.sv
// ctb_pkg: shared types and constants of the countdown timer bank
`timescale 1ns / 1ps

package ctb_pkg;

	// command codes
	localparam logic [3:0] CMD_TICK       = 4'd0;
	localparam logic [3:0] CMD_ALLOC_S    = 4'd1;
	localparam logic [3:0] CMD_ALLOC_L    = 4'd2;
	localparam logic [3:0] CMD_SET_S      = 4'd3;
	localparam logic [3:0] CMD_SET_L      = 4'd4;
	localparam logic [3:0] CMD_READ_S     = 4'd5;
	localparam logic [3:0] CMD_READ_L     = 4'd6;
	localparam logic [3:0] CMD_LOCK_S     = 4'd7;
	localparam logic [3:0] CMD_LOCK_L     = 4'd8;
	localparam logic [3:0] CMD_SET_DELAY  = 4'd9;
	localparam logic [3:0] CMD_READ_TICK  = 4'd10;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOALLOC = 2'd1;
	localparam logic [1:0] ST_NOFREE  = 2'd2;

	// operation applied to one timer as it passes the update point of a ring
	typedef enum logic [1:0] {
		R_NONE,
		R_TICK,
		R_SET,
		R_LOCK
	} ring_op_t;

	// control that a cell receives along with its upstream data
	typedef struct packed {
		logic     apply;
		ring_op_t op;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/ctb_cmd_if.sv
// ctb_cmd_if: command request channel of the countdown timer bank
`timescale 1ns / 1ps

interface ctb_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [3:0]  index;
	logic [31:0] value;

	modport source (output valid, output command, output index, output value, input ready);
	modport sink (input valid, input command, input index, input value, output ready);
endinterface

FILE: hw/rtl/ctb_rsp_if.sv
// ctb_rsp_if: result response channel of the countdown timer bank
`timescale 1ns / 1ps

interface ctb_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	logic [1:0]  status;
	logic        delay_busy;

	modport source (output valid, output data, output status, output delay_busy, input ready);
	modport sink (input valid, input data, input status, input delay_busy, output ready);
endinterface

FILE: hw/rtl/countdown_timer_bank.sv
// countdown_timer_bank: top level with command decode, lap sequencer and result register
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    command[4], index[4], value[32]
//   rsp      out  valid/ready    data[32], status[2], delay_busy[1]
//
// Every request takes one lap of the timer rings over max(SHORT_TIMERS, LONG_TIMERS)
// positions, then a done state hands the result to the output register, waiting while
// that register still holds an unaccepted result. The ring rotation visits one timer
// of each bank per cycle at the single update point, until all its timers have passed.
// Reset clears the allocation counts, delay counter and tick count; timer slots are
// written when allocated. A new request is taken while an earlier result still waits.
`timescale 1ns / 1ps

module countdown_timer_bank #(
	parameter int SHORT_TIMERS = 16,
	parameter int LONG_TIMERS  = 8
) (
	input logic       clk,
	input logic       arst_n,
	ctb_cmd_if.sink   cmd,
	ctb_rsp_if.source rsp
);
	import ctb_pkg::*;

	localparam int LAP   = (SHORT_TIMERS > LONG_TIMERS) ? SHORT_TIMERS : LONG_TIMERS;
	localparam int POS_W = (LAP > 1) ? $clog2(LAP) : 1;
	localparam int SW    = $clog2(SHORT_TIMERS + 1);
	localparam int LW    = $clog2(LONG_TIMERS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] pos_q;
	logic [SW-1:0]    s_used_q;
	logic [LW-1:0]    l_used_q;
	logic [15:0]      delay_q;
	logic [15:0]      tick_q;

	ring_op_t         s_op_q;
	ring_op_t         l_op_q;
	logic [SW-1:0]    s_tgt_q;
	logic [LW-1:0]    l_tgt_q;
	logic [SW-1:0]    s_lim_q;
	logic [LW-1:0]    l_lim_q;
	logic             s_rd_q;
	logic             l_rd_q;
	logic [31:0]      val_q;

	logic [31:0]      res_data_q;
	logic [1:0]       res_status_q;
	logic             res_busy_q;

	logic             rsp_valid_q;
	logic [31:0]      rsp_data_q;
	logic [1:0]       rsp_status_q;
	logic             rsp_busy_q;

	// decoded request
	ring_op_t         s_op_d;
	ring_op_t         l_op_d;
	logic [SW-1:0]    s_tgt_d;
	logic [LW-1:0]    l_tgt_d;
	logic             s_rd_d;
	logic             l_rd_d;
	logic [SW-1:0]    s_used_d;
	logic [LW-1:0]    l_used_d;
	logic [15:0]      delay_d;
	logic [15:0]      tick_d;
	logic [31:0]      data_d;
	logic [1:0]       status_d;
	logic             s_ok;
	logic             l_ok;
	logic             accept;

	logic             s_shift;
	logic             l_shift;
	cell_ctl_t        s_ctl;
	cell_ctl_t        l_ctl;
	logic [15:0]      s_head;
	logic [31:0]      l_head;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	assign s_ok = 32'(cmd.index) < 32'(s_used_q);
	assign l_ok = 32'(cmd.index) < 32'(l_used_q);

	// command decode
	always_comb begin
		s_op_d   = R_NONE;
		l_op_d   = R_NONE;
		s_tgt_d  = SW'(cmd.index);
		l_tgt_d  = LW'(cmd.index);
		s_rd_d   = 1'b0;
		l_rd_d   = 1'b0;
		s_used_d = s_used_q;
		l_used_d = l_used_q;
		delay_d  = delay_q;
		tick_d   = tick_q;
		data_d   = '0;
		status_d = ST_OK;
		unique case (cmd.command)
			CMD_TICK: begin
				s_op_d = R_TICK;
				l_op_d = R_TICK;
				if (delay_q != '0) begin
					delay_d = delay_q - 16'd1;
				end
				tick_d = tick_q + 16'd1;
			end
			CMD_ALLOC_S: begin
				if (32'(s_used_q) >= SHORT_TIMERS) begin
					data_d   = '1;
					status_d = ST_NOFREE;
				end else begin
					data_d   = 32'(s_used_q);
					s_op_d   = R_LOCK;
					s_tgt_d  = s_used_q;
					s_used_d = s_used_q + SW'(1);
				end
			end
			CMD_ALLOC_L: begin
				if (32'(l_used_q) >= LONG_TIMERS) begin
					data_d   = '1;
					status_d = ST_NOFREE;
				end else begin
					data_d   = 32'(l_used_q);
					l_op_d   = R_LOCK;
					l_tgt_d  = l_used_q;
					l_used_d = l_used_q + LW'(1);
				end
			end
			CMD_SET_S: begin
				if (s_ok) s_op_d = R_SET;
				else status_d = ST_NOALLOC;
			end
			CMD_SET_L: begin
				if (l_ok) l_op_d = R_SET;
				else status_d = ST_NOALLOC;
			end
			CMD_READ_S: begin
				if (s_ok) begin
					s_rd_d = 1'b1;
				end else begin
					data_d   = 32'h0000_FFFF;
					status_d = ST_NOALLOC;
				end
			end
			CMD_READ_L: begin
				if (l_ok) begin
					l_rd_d = 1'b1;
				end else begin
					data_d   = '1;
					status_d = ST_NOALLOC;
				end
			end
			CMD_LOCK_S: begin
				if (s_ok) s_op_d = R_LOCK;
				else status_d = ST_NOALLOC;
			end
			CMD_LOCK_L: begin
				if (l_ok) l_op_d = R_LOCK;
				else status_d = ST_NOALLOC;
			end
			CMD_SET_DELAY: delay_d = cmd.value[15:0];
			CMD_READ_TICK: data_d = 32'(tick_q);
			default: ;
		endcase
	end

	// ring control: rotate for bank depth, update addressed position (tick: all allocated)
	always_comb begin
		s_shift   = (state_q == S_RUN) && (32'(pos_q) < SHORT_TIMERS);
		l_shift   = (state_q == S_RUN) && (32'(pos_q) < LONG_TIMERS);
		s_ctl.op  = s_op_q;
		l_ctl.op  = l_op_q;
		s_ctl.apply = s_shift && ((s_op_q == R_TICK) ? (32'(pos_q) < 32'(s_lim_q)) :
			((s_op_q != R_NONE) && (32'(pos_q) == 32'(s_tgt_q))));
		l_ctl.apply = l_shift && ((l_op_q == R_TICK) ? (32'(pos_q) < 32'(l_lim_q)) :
			((l_op_q != R_NONE) && (32'(pos_q) == 32'(l_tgt_q))));
	end

	ctb_ring #(.WIDTH(16), .DEPTH(SHORT_TIMERS)) u_short (
		.clk   (clk),
		.shift (s_shift),
		.ctl   (s_ctl),
		.value (val_q[15:0]),
		.head  (s_head)
	);

	ctb_ring #(.WIDTH(32), .DEPTH(LONG_TIMERS)) u_long (
		.clk   (clk),
		.shift (l_shift),
		.ctl   (l_ctl),
		.value (val_q),
		.head  (l_head)
	);

	// sequencer, bank state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			s_used_q     <= '0;
			l_used_q     <= '0;
			delay_q      <= '0;
			tick_q       <= '0;
			s_op_q       <= R_NONE;
			l_op_q       <= R_NONE;
			s_rd_q       <= 1'b0;
			l_rd_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// the done state refills the output register itself
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						s_op_q       <= s_op_d;
						l_op_q       <= l_op_d;
						s_tgt_q      <= s_tgt_d;
						l_tgt_q      <= l_tgt_d;
						s_lim_q      <= s_used_q;
						l_lim_q      <= l_used_q;
						s_rd_q       <= s_rd_d;
						l_rd_q       <= l_rd_d;
						val_q        <= cmd.value;
						s_used_q     <= s_used_d;
						l_used_q     <= l_used_d;
						delay_q      <= delay_d;
						tick_q       <= tick_d;
						res_data_q   <= data_d;
						res_status_q <= status_d;
						res_busy_q   <= (delay_d != '0);
						pos_q        <= '0;
						state_q      <= S_RUN;
					end
				end
				S_RUN: begin
					// capture a read as the addressed timer reaches the head
					if (s_rd_q && (32'(pos_q) == 32'(s_tgt_q))) begin
						res_data_q <= 32'(s_head);
					end
					if (l_rd_q && (32'(pos_q) == 32'(l_tgt_q))) begin
						res_data_q <= l_head;
					end
					if (32'(pos_q) == LAP - 1) begin
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_data_q   <= res_data_q;
						rsp_status_q <= res_status_q;
						rsp_busy_q   <= res_busy_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.data       = rsp_data_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.delay_busy = rsp_busy_q;

endmodule

FILE: hw/rtl/ctb_cell.sv
// ctb_cell: one timer slot of a ring, takes its neighbor's value and may update it
`timescale 1ns / 1ps

module ctb_cell #(
	parameter int WIDTH = 16
) (
	input  logic               clk,
	input  logic               shift,
	input  ctb_pkg::cell_ctl_t ctl,
	input  logic [WIDTH-1:0]   value,
	input  logic [WIDTH-1:0]   din,
	output logic [WIDTH-1:0]   q
);
	import ctb_pkg::*;

	logic [WIDTH-1:0] nxt;
	logic [WIDTH-1:0] val_q;

	// update of the value that passes in from the neighbor
	always_comb begin
		nxt = din;
		if (ctl.apply) begin
			case (ctl.op)
				R_TICK: begin
					if (din != '0 && din != '1) begin
						nxt = din - WIDTH'(1);
					end
				end
				R_SET:   nxt = value;
				R_LOCK:  nxt = '1;
				default: nxt = din;
			endcase
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= nxt;
		end
	end

	assign q = val_q;

endmodule

FILE: hw/rtl/ctb_ring.sv
// ctb_ring: circular chain of timer cells with one update point
`timescale 1ns / 1ps

module ctb_ring #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               shift,
	input  ctb_pkg::cell_ctl_t ctl,
	input  logic [WIDTH-1:0]   value,
	output logic [WIDTH-1:0]   head
);
	import ctb_pkg::*;

	logic [WIDTH-1:0] q [DEPTH];

	// cell k takes from cell k+1; the last cell takes from cell 0 and holds the update point
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		cell_ctl_t c_ctl;
		if (k == DEPTH - 1) begin : g_upd
			assign c_ctl = ctl;
		end else begin : g_pass
			assign c_ctl = '{apply: 1'b0, op: R_NONE};
		end
		ctb_cell #(.WIDTH(WIDTH)) u_cell (
			.clk   (clk),
			.shift (shift),
			.ctl   (c_ctl),
			.value (value),
			.din   (q[(k + 1) % DEPTH]),
			.q     (q[k])
		);
	end

	// after t shifts of a lap, cell 0 holds timer t
	assign head = q[0];

endmodule

FILE: tb/tb_countdown_timer_bank.sv
// tb_countdown_timer_bank: self-checking testbench for the countdown timer bank
`timescale 1ns / 1ps

module tb_countdown_timer_bank;
	import ctb_pkg::*;

	localparam int SHORT_TIMERS = 16;
	localparam int LONG_TIMERS  = 8;

	localparam logic [3:0]  CMD_UNUSED_LO = 4'd11;
	localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;
	localparam logic [15:0] SHORT_LOCKED  = 16'hFFFF;
	localparam logic [31:0] LONG_LOCKED   = 32'hFFFF_FFFF;

	localparam int RANDOM_REQUESTS  = 1750;
	localparam int STRETCH_REQUESTS = 200;
	localparam int TAIL_REQUESTS    = 50;
	localparam int IDLE_PCT         = 36;
	localparam int DRAIN_CYCLES     = 40;
	localparam int LIMIT_CYCLES     = 400_000;

	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  status;
		logic        busy;
	} result_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [3:0]  idx;
		logic [31:0] val;
		logic        typed;
		result_t     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ctb_cmd_if cmd_ch ();
	ctb_rsp_if rsp_ch ();

	countdown_timer_bank #(
		.SHORT_TIMERS(SHORT_TIMERS),
		.LONG_TIMERS (LONG_TIMERS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the timer bank state
	logic [15:0] short_rem [SHORT_TIMERS];
	logic [31:0] long_rem [LONG_TIMERS];
	logic [4:0]  short_used;
	logic [3:0]  long_used;
	logic [15:0] delay_left;
	logic [15:0] tick_total;

	result_t expected_results[$];

	bit cmd_idle_on = 1'b1;
	bit rsp_idle_on = 1'b1;
	int mismatch_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int refused_allocs = 0;
	int unallocated_hits = 0;
	int ticks_sent = 0;
	int cycle_count = 0;

	// directed requests; typed results where they are obvious, the rest predicted
	stim_row_t stim_rows [26] = '{
		'{CMD_READ_S,    4'd0,  32'd0,         1'b1, '{32'h0000_FFFF, ST_NOALLOC, 1'b0}},
		'{CMD_READ_L,    4'd15, 32'd0,         1'b1, '{32'hFFFF_FFFF, ST_NOALLOC, 1'b0}},
		'{CMD_SET_S,     4'd0,  32'hFFFF_FFFF, 1'b1, '{32'd0, ST_NOALLOC, 1'b0}},
		'{CMD_LOCK_L,    4'd7,  32'd0,         1'b1, '{32'd0, ST_NOALLOC, 1'b0}},
		'{CMD_READ_TICK, 4'd0,  32'd0,         1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_ALLOC_S,   4'd0,  32'd0,         1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_ALLOC_L,   4'd0,  32'd0,         1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_S,    4'd1,  32'd0,         1'b1, '{32'h0000_FFFF, ST_NOALLOC, 1'b0}},
		'{CMD_READ_S,    4'd0,  32'd0,         1'b1, '{32'h0000_FFFF, ST_OK, 1'b0}},
		'{CMD_READ_L,    4'd0,  32'd0,         1'b1, '{32'hFFFF_FFFF, ST_OK, 1'b0}},
		'{CMD_SET_S,     4'd0,  32'hFFFF_0002, 1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_SET_L,     4'd0,  32'h8000_0001, 1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_SET_DELAY, 4'd0,  32'hFFFF_0001, 1'b1, '{32'd0, ST_OK, 1'b1}},
		'{CMD_TICK,      4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_S,    4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_L,    4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_TICK,      4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_TICK,      4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_S,    4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_SET_S,     4'd0,  32'h0000_FFFF, 1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_TICK,      4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_S,    4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_LOCK_L,    4'd0,  32'd0,         1'b1, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_L,    4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_READ_TICK, 4'd0,  32'd0,         1'b0, '{32'd0, ST_OK, 1'b0}},
		'{CMD_UNUSED_HI, 4'd15, 32'hFFFF_FFFF, 1'b1, '{32'd0, ST_OK, 1'b0}}
	};

	// apply one command to the shadow state and return the result it should give
	function automatic result_t timer_bank_step(logic [3:0] op, logic [3:0] idx,
			logic [31:0] val);
		result_t r;
		bit short_hit;
		bit long_hit;
		r = '0;
		short_hit = idx < short_used;
		long_hit  = idx < long_used;
		case (op)
			CMD_TICK: begin
				if (delay_left != 16'd0)
					delay_left = delay_left - 16'd1;
				for (int i = 0; i < SHORT_TIMERS; i++) begin
					if (i < short_used && short_rem[i] != 16'd0 && short_rem[i] != SHORT_LOCKED)
						short_rem[i] = short_rem[i] - 16'd1;
				end
				for (int i = 0; i < LONG_TIMERS; i++) begin
					if (i < long_used && long_rem[i] != 32'd0 && long_rem[i] != LONG_LOCKED)
						long_rem[i] = long_rem[i] - 32'd1;
				end
				tick_total = tick_total + 16'd1;
			end
			CMD_ALLOC_S: begin
				if (short_used >= SHORT_TIMERS) begin
					r.data   = 32'hFFFF_FFFF;
					r.status = ST_NOFREE;
				end else begin
					r.data = 32'(short_used);
					short_rem[short_used] = SHORT_LOCKED;
					short_used = short_used + 5'd1;
				end
			end
			CMD_ALLOC_L: begin
				if (long_used >= LONG_TIMERS) begin
					r.data   = 32'hFFFF_FFFF;
					r.status = ST_NOFREE;
				end else begin
					r.data = 32'(long_used);
					long_rem[long_used] = LONG_LOCKED;
					long_used = long_used + 4'd1;
				end
			end
			CMD_SET_S: begin
				if (short_hit) short_rem[idx] = val[15:0];
				else r.status = ST_NOALLOC;
			end
			CMD_SET_L: begin
				if (long_hit) long_rem[idx] = val;
				else r.status = ST_NOALLOC;
			end
			CMD_READ_S: begin
				if (short_hit) begin
					r.data = {16'd0, short_rem[idx]};
				end else begin
					r.data   = {16'd0, SHORT_LOCKED};
					r.status = ST_NOALLOC;
				end
			end
			CMD_READ_L: begin
				if (long_hit) begin
					r.data = long_rem[idx];
				end else begin
					r.data   = LONG_LOCKED;
					r.status = ST_NOALLOC;
				end
			end
			CMD_LOCK_S: begin
				if (short_hit) short_rem[idx] = SHORT_LOCKED;
				else r.status = ST_NOALLOC;
			end
			CMD_LOCK_L: begin
				if (long_hit) long_rem[idx] = LONG_LOCKED;
				else r.status = ST_NOALLOC;
			end
			CMD_SET_DELAY: delay_left = val[15:0];
			CMD_READ_TICK: r.data = {16'd0, tick_total};
			default: ;
		endcase
		r.busy = (delay_left != 16'd0);
		return r;
	endfunction

	// present one request, wait for acceptance, then queue its result
	task automatic send_request(logic [3:0] op, logic [3:0] idx, logic [31:0] val,
			bit typed, result_t want);
		result_t pred;
		while (cmd_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.index   <= idx;
		cmd_ch.value   <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pred = timer_bank_step(op, idx, val);
		if (op == CMD_TICK)
			ticks_sent++;
		if (pred.status == ST_NOFREE)
			refused_allocs++;
		if (pred.status == ST_NOALLOC)
			unallocated_hits++;
		expected_results.push_back(typed ? want : pred);
		requests_sent++;
	endtask

	// random request, mostly aimed at allocated timers
	task automatic send_random_request();
		int pick;
		int used;
		logic [3:0] op;
		logic [3:0] idx;
		logic [31:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 28)      op = CMD_TICK;
		else if (pick < 30) op = CMD_ALLOC_S;
		else if (pick < 32) op = CMD_ALLOC_L;
		else if (pick < 42) op = CMD_SET_S;
		else if (pick < 52) op = CMD_SET_L;
		else if (pick < 64) op = CMD_READ_S;
		else if (pick < 76) op = CMD_READ_L;
		else if (pick < 81) op = CMD_LOCK_S;
		else if (pick < 86) op = CMD_LOCK_L;
		else if (pick < 91) op = CMD_SET_DELAY;
		else if (pick < 96) op = CMD_READ_TICK;
		else                op = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));

		case (op)
			CMD_SET_S, CMD_READ_S, CMD_LOCK_S: used = short_used;
			default: used = long_used;
		endcase
		if (used != 0 && $urandom_range(0, 99) < 80)
			idx = 4'($urandom_range(0, used - 1));
		else
			idx = 4'($urandom_range(0, 15));

		// small counts run out under ticks; the rest hit locked values and high bits
		case ($urandom_range(0, 5))
			0, 1, 2: val = 32'($urandom_range(0, 40));
			3:       val = $urandom();
			4:       val = {16'($urandom_range(0, 65535)), 16'hFFFF};
			default: val = 32'hFFFF_FFFF ^ 32'($urandom_range(0, 1));
		endcase
		send_request(op, idx, val, 1'b0, '0);
	endtask

	// compare one result against the oldest queued one
	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$error("result with nothing queued: data %h status %0d delay_busy %0b",
				rsp_ch.data, rsp_ch.status, rsp_ch.delay_busy);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			results_checked++;
			if (rsp_ch.data !== want.data) begin
				$error("data: expected %h, got %h", want.data, rsp_ch.data);
				mismatch_count++;
			end
			if (rsp_ch.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
				mismatch_count++;
			end
			if (rsp_ch.delay_busy !== want.busy) begin
				$error("delay_busy: expected %0b, got %0b", want.busy, rsp_ch.delay_busy);
				mismatch_count++;
			end
		end
	endtask

	// result side: check on handshake, stall at random
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			check_result();
		rsp_ch.ready <= !rsp_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.index   = 4'd0;
		cmd_ch.value   = 32'd0;
		short_rem      = '{default: 16'd0};
		long_rem       = '{default: 32'd0};
		short_used     = 5'd0;
		long_used      = 4'd0;
		delay_left     = 16'd0;
		tick_total     = 16'd0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests
		foreach (stim_rows[i])
			send_request(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val,
				stim_rows[i].typed, stim_rows[i].want);

		// random requests with random gaps and stalls
		repeat (RANDOM_REQUESTS)
			send_random_request();

		// a long stretch with no idling on either side
		cmd_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		repeat (STRETCH_REQUESTS)
			send_random_request();
		cmd_idle_on = 1'b1;
		rsp_idle_on = 1'b1;

		// a short random tail with gaps again
		repeat (TAIL_REQUESTS)
			send_random_request();
		cmd_ch.valid <= 1'b0;

		// drain
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d results checked, %0d ticks",
			requests_sent, results_checked, ticks_sent);
		$display("refused allocations %0d, requests on unallocated timers %0d",
			refused_allocs, unallocated_hits);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_cmd_if.sv
hw/rtl/ctb_rsp_if.sv
hw/rtl/ctb_cell.sv
hw/rtl/ctb_ring.sv
hw/rtl/countdown_timer_bank.sv
tb/tb_countdown_timer_bank.sv
